@@ hdl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and types for the Go-Back-N send window block.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WINDOW_DEF = 16;
  localparam int SEQ_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int PKT_CNT_W  = 16;
  localparam int WIN_SIZE_W = 5;
  localparam int OP_W       = 2;
  localparam int ACK_KIND_W = 8;
  localparam int ACK_SEQ_W  = 16;
  localparam int RKIND_W    = 2;
  localparam int SEND_SEQ_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Event codes.
  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // Packet type that marks an acknowledgment.
  localparam logic [ACK_KIND_W-1:0] KIND_ACK = 8'd2;

  // Result codes.
  localparam logic [RKIND_W-1:0] RK_SEND = 2'd0;
  localparam logic [RKIND_W-1:0] RK_IDLE = 2'd1;
  localparam logic [RKIND_W-1:0] RK_DONE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b1;

  localparam logic [WIN_SIZE_W-1:0] WINDOW_SIZE_RST = 5'd4;

  // Controller to datapath.
  typedef struct packed {
    logic load_event;
    logic emit;
  } gbn_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic finished;
    logic fits;
    logic next_fits;
  } gbn_status_t;

endpackage

@@ hdl/gbn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbn_ctrl
// Controller: takes one event, then issues one result per free output slot
// until the run ends. Owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  gbn_status_t status,
  output gbn_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic last;

  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // The run ends on a finished or idle result, or on the final send.
  assign last = status.finished || !status.fits || !status.next_fits;

  assign cmd.load_event = in_valid && !in_stall;
  assign cmd.emit       = (state_r == S_EMIT) && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load_event) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit && last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/gbn_dp.sv @@
// ----------------------------------------------------------------------------
// gbn_dp
// Datapath: configuration registers, window base and in-flight count,
// the fit checks and the output result register.
// ----------------------------------------------------------------------------
module gbn_dp
  import gbn_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [ACK_KIND_W-1:0] in_ack_kind,
  input  logic [ACK_SEQ_W-1:0]  in_ack_seq,
  output logic [RKIND_W-1:0]    out_result_kind,
  output logic [SEND_SEQ_W-1:0] out_send_seq,
  output logic                  out_last_of_run,
  input  gbn_cmd_t              cmd,
  output gbn_status_t           status
);

  localparam int IW  = $clog2(MAX_WINDOW + 1);
  localparam int IW1 = IW + 1;
  localparam int WCW = (IW > WIN_SIZE_W) ? IW : WIN_SIZE_W;
  // Compare width: holds any base plus a window without wrapping.
  localparam int CW  = ((SEQ_BITS > PKT_CNT_W) ? SEQ_BITS : PKT_CNT_W) + 1;

  logic [PKT_CNT_W-1:0]  pc_r;
  logic [WIN_SIZE_W-1:0] ws_r;
  logic [SEQ_BITS-1:0]   base_r, base_nxt;
  logic [IW-1:0]         inf_r, inf_nxt;
  logic [RKIND_W-1:0]    kind_r;
  logic [SEND_SEQ_W-1:0] seq_r;
  logic                  last_r;

  logic [WCW-1:0] ws_ext;
  logic [IW-1:0]  win;
  logic [CW-1:0]  pc_ext;
  logic [CW-1:0]  sum;
  logic [CW-1:0]  sum1;
  logic [IW1-1:0] inf1;
  logic           ack_ok;

  // A window size of zero acts as one; anything above the maximum is clipped.
  always_comb begin
    ws_ext = WCW'(ws_r);
    if (ws_r == '0) begin
      win = IW'(1);
    end else if (ws_ext > WCW'(MAX_WINDOW)) begin
      win = IW'(MAX_WINDOW);
    end else begin
      win = IW'(ws_ext);
    end
  end

  assign pc_ext = CW'(pc_r);
  assign sum    = CW'(base_r) + CW'(inf_r);
  assign sum1   = sum + CW'(1);
  assign inf1   = IW1'(inf_r) + IW1'(1);

  assign status.finished  = (CW'(base_r) >= pc_ext);
  assign status.fits      = (inf_r < win) && (sum < pc_ext);
  assign status.next_fits = (inf1 < IW1'(win)) && (sum1 < pc_ext);

  // Only an exact-base acknowledgment before the end of the transfer counts.
  assign ack_ok = (CW'(base_r) < pc_ext) && (in_ack_kind == KIND_ACK) &&
                  (CW'(in_ack_seq) == CW'(base_r));

  always_comb begin
    base_nxt = base_r;
    inf_nxt  = inf_r;
    if (cmd.load_event) begin
      case (in_operation)
        OP_START: begin
          base_nxt = '0;
          inf_nxt  = '0;
        end
        OP_ACK: begin
          if (ack_ok) begin
            base_nxt = base_r + SEQ_BITS'(1);
            if (inf_r != '0) begin
              inf_nxt = inf_r - IW'(1);
            end
          end
        end
        OP_TIMEOUT: begin
          inf_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.emit && !status.finished && status.fits) begin
      inf_nxt = inf_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      ws_r   <= WINDOW_SIZE_RST;
      base_r <= '0;
      inf_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PACKET_COUNT: pc_r <= cfg_wdata;
          REG_WINDOW_SIZE:  ws_r <= cfg_wdata[WIN_SIZE_W-1:0];
          default: begin
          end
        endcase
      end
      base_r <= base_nxt;
      inf_r  <= inf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (status.finished) begin
        kind_r <= RK_DONE;
        seq_r  <= '0;
        last_r <= 1'b1;
      end else if (!status.fits) begin
        kind_r <= RK_IDLE;
        seq_r  <= '0;
        last_r <= 1'b1;
      end else begin
        kind_r <= RK_SEND;
        seq_r  <= SEND_SEQ_W'(SEQ_BITS'(sum));
        last_r <= !status.next_fits;
      end
    end
  end

  assign out_result_kind = kind_r;
  assign out_send_seq    = seq_r;
  assign out_last_of_run = last_r;

endmodule

@@ hdl/go_back_n_send_window.sv @@
// ----------------------------------------------------------------------------
// go_back_n_send_window
// Go-Back-N sender window control: each event updates the window and is
// followed by sends for every packet that now fits, else one idle or done result.
// ----------------------------------------------------------------------------
//  Port group | Direction | Handshake          | Contents
//  in_*       | input     | in_valid/in_stall  | operation, ack_kind, ack_seq
//  out_*      | output    | out_valid/out_stall| result_kind, send_seq, last_of_run
//  cfg_*      | input     | cfg_we             | cfg_index, cfg_wdata
//
// An item is taken in and applied, then the result loop loads the single output
// register with one result per cycle while the output is not stalled: n results,
// with n from 1 to MAX_WINDOW. The next item is taken once the final result of a
// run is in the output register. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module go_back_n_send_window
  import gbn_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [ACK_KIND_W-1:0] in_ack_kind,
  input  logic [ACK_SEQ_W-1:0]  in_ack_seq,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RKIND_W-1:0]    out_result_kind,
  output logic [SEND_SEQ_W-1:0] out_send_seq,
  output logic                  out_last_of_run
);

  gbn_cmd_t    cmd;
  gbn_status_t status;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gbn_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_operation),
    .in_ack_kind     (in_ack_kind),
    .in_ack_seq      (in_ack_seq),
    .out_result_kind (out_result_kind),
    .out_send_seq    (out_send_seq),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
